FILE: rtl/core/glu_pkg.sv
// Shared types and constants for the GCD / LCM unit.
`timescale 1ns / 1ps

package glu_pkg;

    // Port field widths
    localparam int FIELD_W  = 32;
    localparam int RESULT_W = 64;
    localparam int TDATA_W  = 2 * FIELD_W;

    // Operation select carried on s_tuser
    localparam logic CMD_GCD = 1'b0;
    localparam logic CMD_LCM = 1'b1;

    // Handshake between the sequencer and an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

FILE: rtl/core/glu_divider.sv
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
`timescale 1ns / 1ps

module glu_divider #(
    parameter int WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [WIDTH-1:0]      dividend,
    input  logic [WIDTH-1:0]      divisor,
    output logic [WIDTH-1:0]      quotient,
    output logic [WIDTH-1:0]      remainder,
    output glu_pkg::unit_status_t status
);
    import glu_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg, quo_reg, dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;

    logic [WIDTH:0]   trial;
    logic             borrow;

    // Bring down the next dividend bit and try the subtract
    assign trial  = {rem_reg, quo_reg[WIDTH-1]} - {1'b0, dvs_reg};
    assign borrow = trial[WIDTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                cnt_reg  <= CNT_W'(WIDTH);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= borrow ? {rem_reg[WIDTH-2:0], quo_reg[WIDTH-1]}
                                  : trial[WIDTH-1:0];
                quo_reg <= {quo_reg[WIDTH-2:0], ~borrow};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

FILE: rtl/core/glu_multiplier.sv
// Shift-and-add multiplier, one multiplier bit per cycle, double-width product.
`timescale 1ns / 1ps

module glu_multiplier #(
    parameter int WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [WIDTH-1:0]      multiplicand,
    input  logic [WIDTH-1:0]      multiplier,
    output logic [2*WIDTH-1:0]    product,
    output glu_pkg::unit_status_t status
);
    import glu_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [2*WIDTH-1:0] acc_reg, mcd_reg;
    logic [WIDTH-1:0]   mpl_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg, done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                acc_reg  <= '0;
                mcd_reg  <= {{WIDTH{1'b0}}, multiplicand};
                mpl_reg  <= multiplier;
                cnt_reg  <= CNT_W'(WIDTH);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (mpl_reg[0]) begin
                    acc_reg <= acc_reg + mcd_reg;
                end
                mcd_reg <= {mcd_reg[2*WIDTH-2:0], 1'b0};
                mpl_reg <= {1'b0, mpl_reg[WIDTH-1:1]};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

FILE: rtl/core/gcd_lcm_unit.sv
// GCD / LCM unit: top level with the Euclid sequencer and stream handshake.
//
// Usage: one beat on the s_ channel carries two unsigned operands and a
// command (s_tuser: 0 = GCD, 1 = LCM). Only the low OPERAND_WIDTH bits of
// each operand are used. One beat comes back on the m_ channel: the GCD
// zero-extended to 64 bits, or the full double-width LCM.
// GCD: Euclid remainder steps; each remainder runs on the shared
// restoring divider, with one compare in ST_EUCLID before each step.
// No remainder step is run if either operand is zero. LCM adds one more
// divide (a / gcd) and a shift-add multiply; a zero operand gives 0
// right after the gcd check.
// One item is in flight at a time: s_tready is high only while idle, and the
// next item is taken the cycle after the result beat is accepted.
// A stalled receiver holds the result in the output register until
// m_tready; nothing is lost. Reset (aresetn low, synchronous) drops any item
// in progress and returns to idle; the unit keeps no state between items.
`timescale 1ns / 1ps

module gcd_lcm_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [glu_pkg::TDATA_W-1:0]  s_tdata,   // operand_a [31:0], operand_b [63:32]
    input  logic                         s_tuser,   // command [0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [glu_pkg::RESULT_W-1:0] m_tdata    // result_value [63:0]
);
    import glu_pkg::*;

    localparam int W = OPERAND_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EUCLID,
        ST_REM,
        ST_QUOT,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t            state_reg;
    logic              cmd_reg;
    logic [W-1:0]      a_reg, b_reg;
    logic [W-1:0]      x_reg, y_reg;
    logic              x_big_reg;
    logic [RESULT_W-1:0] res_reg;

    logic              div_start_reg;
    logic [W-1:0]      div_dvd_reg, div_dvs_reg;
    logic              mul_start_reg;
    logic [W-1:0]      mul_mcd_reg;

    logic [W-1:0]      div_quo, div_rem;
    logic [2*W-1:0]    mul_prod;
    unit_status_t      div_stat, mul_stat;

    logic [W-1:0]      gcd_val;

    assign gcd_val = x_reg | y_reg;   // one of them is zero when used

    glu_divider #(
        .WIDTH (W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start_reg),
        .dividend  (div_dvd_reg),
        .divisor   (div_dvs_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .status    (div_stat)
    );

    glu_multiplier #(
        .WIDTH (W)
    ) u_mul (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (mul_start_reg),
        .multiplicand (mul_mcd_reg),
        .multiplier   (b_reg),
        .product      (mul_prod),
        .status       (mul_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg   <= s_tuser;
                        a_reg     <= s_tdata[W-1:0];
                        b_reg     <= s_tdata[FIELD_W +: W];
                        x_reg     <= s_tdata[W-1:0];
                        y_reg     <= s_tdata[FIELD_W +: W];
                        state_reg <= ST_EUCLID;
                    end
                end
                ST_EUCLID: begin
                    if (x_reg == '0 || y_reg == '0) begin
                        if (cmd_reg == CMD_GCD) begin
                            res_reg   <= RESULT_W'(gcd_val);
                            state_reg <= ST_OUT;
                        end else if (a_reg == '0 || b_reg == '0) begin
                            res_reg   <= '0;
                            state_reg <= ST_OUT;
                        end else if (!div_stat.busy) begin
                            // lcm = (a / g) * b
                            div_dvd_reg   <= a_reg;
                            div_dvs_reg   <= gcd_val;
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_QUOT;
                        end
                    end else if (!div_stat.busy) begin
                        x_big_reg     <= (x_reg > y_reg);
                        div_dvd_reg   <= (x_reg > y_reg) ? x_reg : y_reg;
                        div_dvs_reg   <= (x_reg > y_reg) ? y_reg : x_reg;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_REM;
                    end
                end
                ST_REM: begin
                    if (div_stat.done) begin
                        if (x_big_reg) begin
                            x_reg <= div_rem;
                        end else begin
                            y_reg <= div_rem;
                        end
                        state_reg <= ST_EUCLID;
                    end
                end
                ST_QUOT: begin
                    if (div_stat.done) begin
                        mul_mcd_reg   <= div_quo;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mul_stat.done) begin
                        res_reg   <= RESULT_W'(mul_prod);
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = res_reg;

endmodule
